FILE: rtl/core/base64_codec_core_macros.svh
// assertion helpers for the base64 codec core
`ifndef BASE64_CODEC_CORE_MACROS_SVH
`define BASE64_CODEC_CORE_MACROS_SVH

// checked only outside reset
`define B64_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// checked on every edge, reset included
`define B64_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: rtl/core/b64_pkg.sv
package b64_pkg;

   localparam logic       DIR_ENCODE   = 1'b0;
   localparam logic       DIR_DECODE   = 1'b1;
   localparam logic       REG_DIRECTION = 1'b0;
   localparam logic [7:0] PAD_CHAR     = 8'h3d;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last;
   } req_beat_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_last;
      logic       no_data;
   } rsp_beat_type;

   typedef struct packed {
      logic [3:0][7:0] chars;
      logic [1:0]      final_idx;
      logic            last;
      logic            no_data;
   } job_type;

   typedef struct packed {
      logic    push;
      job_type job;
   } queue_push_type;

   typedef struct packed {
      logic    valid;
      job_type job;
   } queue_head_type;

   typedef struct packed {
      logic       valid;
      logic [5:0] value;
   } sextet_type;

   function automatic logic [7:0] b64_char(input logic [5:0] s);
      logic [7:0] c;
      if (s < 6'd26) begin
         c = 8'h41 + {2'b00, s};
      end else if (s < 6'd52) begin
         c = 8'h61 + {2'b00, s} - 8'd26;
      end else if (s < 6'd62) begin
         c = 8'h30 + {2'b00, s} - 8'd52;
      end else if (s == 6'd62) begin
         c = 8'h2b;
      end else begin
         c = 8'h2f;
      end
      return c;
   endfunction

   function automatic sextet_type b64_sextet(input logic [7:0] c);
      sextet_type r;
      r.valid = 1'b1;
      r.value = 6'd0;
      if (c >= 8'h41 && c <= 8'h5a) begin
         r.value = 6'(c - 8'h41);
      end else if (c >= 8'h61 && c <= 8'h7a) begin
         r.value = 6'(c - 8'h61 + 8'd26);
      end else if (c >= 8'h30 && c <= 8'h39) begin
         r.value = 6'(c - 8'h30 + 8'd52);
      end else if (c == 8'h2b) begin
         r.value = 6'd62;
      end else if (c == 8'h2f) begin
         r.value = 6'd63;
      end else begin
         r.valid = 1'b0;
      end
      return r;
   endfunction

endpackage

FILE: rtl/core/b64_front.sv
module b64_front
   import b64_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   input  req_beat_type   req_data,
   output logic           req_stall,
   input  logic           direction,
   input  logic           queue_full,
   output queue_push_type push
);

   logic [15:0] pend_bytes_ff, pend_bytes_in;
   logic [1:0]  pend_count_ff, pend_count_in;
   logic [7:0]  acc_ff, acc_in;
   logic [2:0]  bit_count_ff, bit_count_in;

   logic        accept;
   logic        flush;
   logic [23:0] group;
   sextet_type  sx;
   logic [3:0]  bits;
   logic [3:0]  bits_left;
   logic [13:0] acc_new;
   logic        emit;
   logic [7:0]  dec_byte;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   always_comb begin
      pend_bytes_in = pend_bytes_ff;
      pend_count_in = pend_count_ff;
      acc_in        = acc_ff;
      bit_count_in  = bit_count_ff;
      push          = '0;

      flush = (pend_count_ff == 2'd2) || req_data.last;
      case (pend_count_ff)
         2'd0:    group = {req_data.data_byte, 16'h0000};
         2'd1:    group = {pend_bytes_ff[7:0], req_data.data_byte, 8'h00};
         default: group = {pend_bytes_ff, req_data.data_byte};
      endcase

      sx       = b64_sextet(req_data.data_byte);
      acc_new  = {acc_ff, sx.value};
      bits     = {1'b0, bit_count_ff} + 4'd6;
      emit     = sx.valid && (bits >= 4'd8);
      bits_left = bits - 4'd8;
      case (bits_left)
         4'd0:    dec_byte = acc_new[7:0];
         4'd2:    dec_byte = acc_new[9:2];
         default: dec_byte = acc_new[11:4];
      endcase

      if (accept) begin
         if (direction == DIR_ENCODE) begin
            if (flush) begin
               push.push              = 1'b1;
               push.job.chars[0]      = b64_char(group[23:18]);
               push.job.chars[1]      = b64_char(group[17:12]);
               push.job.chars[2]      = (pend_count_ff != 2'd0) ?
                                        b64_char(group[11:6]) : PAD_CHAR;
               push.job.chars[3]      = (pend_count_ff == 2'd2) ?
                                        b64_char(group[5:0]) : PAD_CHAR;
               push.job.final_idx     = 2'd3;
               push.job.last          = req_data.last;
               push.job.no_data       = 1'b0;
               pend_bytes_in          = '0;
               pend_count_in          = '0;
               if (req_data.last) begin
                  acc_in       = '0;
                  bit_count_in = '0;
               end
            end else begin
               pend_bytes_in = {pend_bytes_ff[7:0], req_data.data_byte};
               pend_count_in = pend_count_ff + 2'd1;
            end
         end else begin
            if (sx.valid) begin
               acc_in       = acc_new[7:0];
               bit_count_in = emit ? bits_left[2:0] : bits[2:0];
            end
            if (emit || req_data.last) begin
               push.push          = 1'b1;
               push.job.chars[0]  = emit ? dec_byte : 8'h00;
               push.job.final_idx = 2'd0;
               push.job.last      = req_data.last;
               push.job.no_data   = !emit;
            end
            if (req_data.last) begin
               pend_bytes_in = '0;
               pend_count_in = '0;
               acc_in        = '0;
               bit_count_in  = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_bytes_ff <= '0;
         pend_count_ff <= '0;
         acc_ff        <= '0;
         bit_count_ff  <= '0;
      end else begin
         pend_bytes_ff <= pend_bytes_in;
         pend_count_ff <= pend_count_in;
         acc_ff        <= acc_in;
         bit_count_ff  <= bit_count_in;
      end
   end

endmodule

FILE: rtl/core/b64_fifo.sv
module b64_fifo
   import b64_pkg::*;
#(
   parameter int DEPTH = 2
) (
   input  logic           clock,
   input  logic           reset,
   input  queue_push_type push,
   input  logic           pop,
   output logic           full,
   output queue_head_type head
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   job_type         mem_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            do_push;
   logic            do_pop;

   function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
      return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
   endfunction

   assign full       = (count_ff == CW'(DEPTH));
   assign do_push    = push.push && !full;
   assign do_pop     = pop && (count_ff != '0);
   assign head.valid = (count_ff != '0);
   assign head.job   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push.job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: rtl/core/b64_back.sv
module b64_back
   import b64_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  queue_head_type head,
   output logic           pop,
   output logic           rsp_valid,
   output rsp_beat_type   rsp_data,
   input  logic           rsp_stall
);

   logic         rsp_valid_ff, rsp_valid_in;
   rsp_beat_type rsp_data_ff, rsp_data_in;
   logic [1:0]   beat_idx_ff, beat_idx_in;
   logic         load;
   logic         take;
   logic         final_beat;

   assign load       = !rsp_valid_ff || !rsp_stall;
   assign take       = load && head.valid;
   assign final_beat = (beat_idx_ff == head.job.final_idx);
   assign pop        = take && final_beat;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   always_comb begin
      rsp_valid_in = load ? head.valid : rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      beat_idx_in  = beat_idx_ff;
      if (take) begin
         rsp_data_in.out_byte = head.job.chars[beat_idx_ff];
         rsp_data_in.out_last = final_beat && head.job.last;
         rsp_data_in.no_data  = final_beat && head.job.no_data;
         beat_idx_in          = final_beat ? 2'd0 : beat_idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         beat_idx_ff  <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         beat_idx_ff  <= beat_idx_in;
      end
   end

endmodule

FILE: rtl/core/base64_codec_core.sv
// base64 codec core, standard alphabet, direction picked by a register
// req channel: one beat per byte (encode) or character (decode), last ends
//   the message; a beat is taken when req_valid is high and req_stall low
// rsp channel: one beat per output character or byte, out_last on the
//   final beat of a message, no_data on a decode end marker without a byte
// apb port: register direction at address 0 (0 encode, 1 decode), change
//   it only while no message is in flight
// a pushed group is registered in the queue, then in the rsp output register
// throughput: the rsp output register issues one beat per cycle while
//   rsp_stall is low; encode gives four beats per three bytes, so bytes
//   flow slower than beats, decode at one character per cycle
// a queue of QUEUE_DEPTH groups sits between the classifier and the beat
//   serializer; req_stall rises only when that queue is full
// reset: synchronous, clears all group and bit state, direction goes to
//   encode, rsp_valid drops
// while rsp_stall is high the held beat stays put and the queue fills
`include "base64_codec_core_macros.svh"

module base64_codec_core
   import b64_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  req_beat_type req_data,
   output logic         req_stall,
   output logic         rsp_valid,
   output rsp_beat_type rsp_data,
   input  logic         rsp_stall,
   input  logic         psel,
   input  logic         penable,
   input  logic         pwrite,
   input  logic [2:0]   paddr,
   input  logic [31:0]  pwdata,
   output logic [31:0]  prdata,
   output logic         pready
);

   logic           direction_ff, direction_in;
   logic           queue_full;
   logic           queue_pop;
   queue_push_type queue_push;
   queue_head_type queue_head;
   logic           reg_hit;

   assign pready  = 1'b1;
   assign reg_hit = (paddr[2] == REG_DIRECTION);
   assign prdata  = reg_hit ? {31'd0, direction_ff} : 32'd0;

   always_comb begin
      direction_in = direction_ff;
      if (psel && penable && pwrite && pready && reg_hit) begin
         direction_in = pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff <= DIR_ENCODE;
      end else begin
         direction_ff <= direction_in;
      end
   end

   b64_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_data   (req_data),
      .req_stall  (req_stall),
      .direction  (direction_ff),
      .queue_full (queue_full),
      .push       (queue_push)
   );

   b64_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock (clock),
      .reset (reset),
      .push  (queue_push),
      .pop   (queue_pop),
      .full  (queue_full),
      .head  (queue_head)
   );

   b64_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (queue_head),
      .pop       (queue_pop),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_stall (rsp_stall)
   );

   `B64_ASSERT(a_push_room, queue_push.push |-> !queue_full, "group pushed into a full queue")
   `B64_ASSERT(a_marker_form, rsp_valid && rsp_data.no_data |-> rsp_data.out_last && rsp_data.out_byte == 8'h00, "end marker beat malformed")
   `B64_ASSERT_ALWAYS(a_reset_quiet, $past(reset) |-> !rsp_valid, "rsp beat valid right after reset")

endmodule
